FILE: sv/periodic_task_dispatcher_assert.svh
// Assertion macros for the periodic task dispatcher RTL.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH

// cons must hold whenever ante holds, same cycle
`define PTD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptd assertion failed");

// cons must hold in the cycle after ante
`define PTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptd assertion failed");

`endif

FILE: sv/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
// No dependencies.
`default_nettype none
package ptd_pkg;

    localparam int OVR_W        = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int RUN_N_W      = $clog2(MAX_RESULTS + 1);
    localparam logic [OVR_W-1:0] OVR_MAX = {OVR_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_TICK = 2'd1,
        OP_RUN  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_IDLE     = 2'd3
    } t_kind;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic add;
        logic tick;
        logic start;
        logic step;
        logic finish;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: sv/ptd_cell.sv
// One slot of the dispatcher: interval, counter, overrun count, due mark,
// and one stage of the run token chain. Depends on ptd_pkg.
`default_nettype none
module ptd_cell #(
    parameter int TICK_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ptd_pkg::t_cell_ctl          i_ctl,
    input  wire logic                        i_add_sel,
    input  wire logic [TICK_WIDTH-1:0]       i_interval,
    input  wire logic                        i_tok_prev,
    input  wire logic                        i_later,
    output logic                             o_tok,
    output logic                             o_due,
    output logic                             o_later,
    output logic [ptd_pkg::OVR_W-1:0]        o_overruns
);

    logic                       r_occ;
    logic                       r_due;
    logic                       r_tok;
    logic [TICK_WIDTH-1:0]      r_interval;
    logic [TICK_WIDTH-1:0]      r_counter;
    logic [ptd_pkg::OVR_W-1:0]  r_overruns;
    logic [TICK_WIDTH-1:0]      w_cnt1;
    logic                       w_reach;
    logic                       w_add;
    logic                       w_tick;

    assign w_cnt1  = r_counter + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
    assign w_reach = (w_cnt1 >= r_interval);
    assign w_add   = i_ctl.add && i_add_sel;
    assign w_tick  = i_ctl.tick && r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_due <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            if (w_add) begin
                r_occ <= 1'b1;
                r_due <= 1'b0;
            end else if (w_tick && w_reach) begin
                r_due <= 1'b1;
            end else if (i_ctl.step && r_tok) begin
                r_due <= 1'b0;
            end
            if (i_ctl.start) begin
                r_tok <= i_tok_prev;
            end else if (i_ctl.step) begin
                r_tok <= i_tok_prev && !i_ctl.finish;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add) begin
            r_interval <= i_interval;
            r_counter  <= '0;
            r_overruns <= '0;
        end else if (w_tick) begin
            if (w_reach) begin
                r_counter <= '0;
                if (r_due && r_overruns != ptd_pkg::OVR_MAX) begin
                    r_overruns <= r_overruns + 1'b1;
                end
            end else begin
                r_counter <= w_cnt1;
            end
        end
    end

    assign o_tok      = r_tok;
    assign o_due      = r_due;
    assign o_later    = r_due || i_later;
    assign o_overruns = r_overruns;

endmodule
`default_nettype wire

FILE: sv/periodic_task_dispatcher.sv
// Periodic task dispatcher: output register, run sequencer, row of slot cells.
// Add and tick answer in the cycle after the beat; a run walks the chain one slot per cycle.
// Add, tick, empty run: registered next cycle, 1 beat per cycle while idle, output free.
// A run steps the token down the cell chain to the last due slot or MAX_RESULTS dispatches.
// Output stalls pause the walk. Reset clears slot count, due marks and the token;
// intervals are undefined until written, no clearing pass.
`default_nettype none
module periodic_task_dispatcher #(
    parameter int MAX_TASKS  = 16,
    parameter int TICK_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_task_present,
    input  wire logic [31:0] i_interval,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic             o_accepted,
    output logic [3:0]       o_task_index,
    output logic [15:0]      o_overruns,
    output logic             o_last
);

    `include "periodic_task_dispatcher_assert.svh"

    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [ptd_pkg::RUN_N_W-1:0]     r_n, n_n;
    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_kind, n_kind;
    logic                            r_accepted, n_accepted;
    logic [3:0]                      r_task_index, n_task_index;
    logic [15:0]                     r_overruns, n_overruns;
    logic                            r_last, n_last;

    ptd_pkg::t_cell_ctl              w_ctl;
    logic [MAX_TASKS-1:0]            w_tok;
    logic [MAX_TASKS-1:0]            w_due;
    logic [MAX_TASKS:0]              w_later;
    logic [MAX_TASKS-1:0]            w_add_sel;
    logic [ptd_pkg::OVR_W-1:0]       w_ovr [MAX_TASKS];
    logic [TICK_WIDTH-1:0]           w_interval;
    logic                            w_out_free;
    logic                            w_in_acc;
    logic                            w_step;
    logic                            w_full;
    logic                            w_hit;
    logic                            w_more;
    logic                            w_last;
    logic [3:0]                      w_hit_idx;
    logic [ptd_pkg::OVR_W-1:0]       w_hit_ovr;

    assign w_interval = TICK_WIDTH'(i_interval);
    assign w_full     = (r_count == CNT_W'(MAX_TASKS));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_step     = (r_state == S_RUN) && w_out_free;

    assign w_ctl.add    = w_in_acc && (i_operation == ptd_pkg::OP_ADD) &&
                          i_task_present && !w_full;
    assign w_ctl.tick   = w_in_acc && (i_operation == ptd_pkg::OP_TICK);
    assign w_ctl.start  = w_in_acc && (i_operation == ptd_pkg::OP_RUN) && w_later[0];
    assign w_ctl.step   = w_step;
    assign w_ctl.finish = w_step && w_hit && w_last;

    assign w_later[MAX_TASKS] = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        logic w_tok_prev;
        assign w_add_sel[g] = (r_count == CNT_W'(g));
        if (g == 0) begin : g_head
            assign w_tok_prev = w_ctl.start;
        end else begin : g_body
            assign w_tok_prev = w_tok[g-1];
        end
        ptd_cell #(
            .TICK_WIDTH(TICK_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_add_sel  (w_add_sel[g]),
            .i_interval (w_interval),
            .i_tok_prev (w_tok_prev),
            .i_later    (w_later[g+1]),
            .o_tok      (w_tok[g]),
            .o_due      (w_due[g]),
            .o_later    (w_later[g]),
            .o_overruns (w_ovr[g])
        );
    end

    // select the slot holding the run token
    always_comb begin
        w_hit     = 1'b0;
        w_more    = 1'b0;
        w_hit_idx = '0;
        w_hit_ovr = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (w_tok[i]) begin
                w_hit     = w_hit | w_due[i];
                w_more    = w_more | w_later[i+1];
                w_hit_idx = w_hit_idx | 4'(i);
                w_hit_ovr = w_hit_ovr | w_ovr[i];
            end
        end
    end

    assign w_last = !w_more || (r_n == ptd_pkg::RUN_N_W'(ptd_pkg::MAX_RESULTS - 1));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_n          = r_n;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_accepted   = r_accepted;
        n_task_index = r_task_index;
        n_overruns   = r_overruns;
        n_last       = r_last;
        if (w_out_free) begin
            n_out_valid = 1'b0;
        end
        if (w_in_acc) begin
            case (i_operation)
                ptd_pkg::OP_ADD: begin
                    n_out_valid  = 1'b1;
                    n_kind       = ptd_pkg::KIND_ADD;
                    n_accepted   = w_ctl.add;
                    n_task_index = w_ctl.add ? 4'(r_count) : 4'd0;
                    n_overruns   = '0;
                    n_last       = 1'b1;
                    if (w_ctl.add) begin
                        n_count = r_count + 1'b1;
                    end
                end
                ptd_pkg::OP_TICK: begin
                    n_out_valid  = 1'b1;
                    n_kind       = ptd_pkg::KIND_TICK;
                    n_accepted   = 1'b0;
                    n_task_index = '0;
                    n_overruns   = '0;
                    n_last       = 1'b1;
                end
                ptd_pkg::OP_RUN: begin
                    n_n = '0;
                    if (w_ctl.start) begin
                        n_state = S_RUN;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_kind       = ptd_pkg::KIND_IDLE;
                        n_accepted   = 1'b0;
                        n_task_index = '0;
                        n_overruns   = '0;
                        n_last       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (w_step && w_hit) begin
            n_out_valid  = 1'b1;
            n_kind       = ptd_pkg::KIND_DISPATCH;
            n_accepted   = 1'b0;
            n_task_index = w_hit_idx;
            n_overruns   = w_hit_ovr;
            n_last       = w_last;
            n_n          = r_n + 1'b1;
            if (w_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_accepted   <= n_accepted;
        r_task_index <= n_task_index;
        r_overruns   <= n_overruns;
        r_last       <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_accepted   = r_accepted;
    assign o_task_index = r_task_index;
    assign o_overruns   = r_overruns;
    assign o_last       = r_last;

    `PTD_ASSERT_SAME(a_tok_onehot0, 1'b1, $onehot0(w_tok))
    `PTD_ASSERT_SAME(a_run_has_tok, r_state == S_RUN, $onehot(w_tok))
    `PTD_ASSERT_SAME(a_run_count, 1'b1, r_n <= ptd_pkg::RUN_N_W'(ptd_pkg::MAX_RESULTS))
    `PTD_ASSERT_NEXT(a_finish_idle, w_ctl.finish, r_state == S_IDLE && w_tok == '0)

endmodule
`default_nettype wire

FILE: tb/periodic_task_dispatcher_checker.sv
// Checker for the periodic task dispatcher: watches both channels, predicts each result
// from its own copy of the slot table and compares beat by beat.
// Depends on ptd_pkg for operation and result codes.
module periodic_task_dispatcher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_task_present,
    input  logic [31:0] i_interval,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_accepted,
    input  logic [3:0]  i_task_index,
    input  logic [15:0] i_overruns,
    input  logic        i_last,
    output int          o_errors,
    output int          o_outstanding,
    output int          o_dispatches,
    output int          o_widest_run
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int PRINT_CAP  = 50;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [3:0]  index;
        logic [15:0] overruns;
        logic        last;
    } t_answer;

    t_answer     answers_due[$];
    logic [31:0] slot_period [SLOTS];
    logic [31:0] slot_ticks  [SLOTS];
    logic [15:0] slot_misses [SLOTS];
    logic        slot_due    [SLOTS];
    int          slots_used  = 0;
    int          errors      = 0;
    int          outstanding = 0;
    int          dispatches  = 0;
    int          widest_run  = 0;
    int          results_seen = 0;

    assign o_errors      = errors;
    assign o_outstanding = outstanding;
    assign o_dispatches  = dispatches;
    assign o_widest_run  = widest_run;

    task automatic report_mismatch(input string what);
        if (errors < PRINT_CAP) begin
            $display("MISMATCH at %0t, result %0d: %s", $realtime, results_seen, what);
        end
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic predict_request(input logic [1:0] op, input logic present,
                                   input logic [31:0] ivl);
        t_answer a;
        int      n;
        a = '0;
        n = 0;
        case (op)
            ptd_pkg::OP_ADD: begin
                a.kind = ptd_pkg::KIND_ADD;
                a.last = 1'b1;
                if (present && slots_used < SLOTS) begin
                    slot_period[slots_used] = ivl;
                    slot_ticks[slots_used]  = '0;
                    slot_misses[slots_used] = '0;
                    slot_due[slots_used]    = 1'b0;
                    a.accepted = 1'b1;
                    a.index    = slots_used[3:0];
                    slots_used++;
                end
                answers_due.push_back(a);
            end
            ptd_pkg::OP_TICK: begin
                for (int i = 0; i < slots_used; i++) begin
                    slot_ticks[i] = slot_ticks[i] + 32'd1;
                    if (slot_ticks[i] >= slot_period[i]) begin
                        if (slot_due[i] && slot_misses[i] != ptd_pkg::OVR_MAX) begin
                            slot_misses[i] = slot_misses[i] + 16'd1;
                        end
                        slot_due[i]   = 1'b1;
                        slot_ticks[i] = '0;
                    end
                end
                a.kind = ptd_pkg::KIND_TICK;
                a.last = 1'b1;
                answers_due.push_back(a);
            end
            ptd_pkg::OP_RUN: begin
                for (int i = 0; i < slots_used; i++) begin
                    if (slot_due[i] && n < ptd_pkg::MAX_RESULTS) begin
                        if (n > 0) begin
                            answers_due.push_back(a);
                        end
                        slot_due[i] = 1'b0;
                        a          = '0;
                        a.kind     = ptd_pkg::KIND_DISPATCH;
                        a.index    = i[3:0];
                        a.overruns = slot_misses[i];
                        n++;
                    end
                end
                if (n == 0) begin
                    a.kind = ptd_pkg::KIND_IDLE;
                end
                a.last = 1'b1;
                answers_due.push_back(a);
                dispatches += n;
                if (n > widest_run) begin
                    widest_run = n;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_answer();
        t_answer want;
        if (answers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d index %0d",
                                      i_kind, i_task_index));
        end else begin
            want = answers_due.pop_front();
            check_field("kind", i_kind, want.kind);
            check_field("accepted", i_accepted, want.accepted);
            check_field("task_index", i_task_index, want.index);
            check_field("overruns", i_overruns, want.overruns);
            check_field("last", i_last, want.last);
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slots_used = 0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_ticks[i]  = '0;
                slot_misses[i] = '0;
                slot_due[i]    = 1'b0;
            end
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_answer();
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_operation, i_task_present, i_interval);
            end
        end
        outstanding <= answers_due.size();
    end

endmodule

FILE: tb/periodic_task_dispatcher_test.sv
// Top of the periodic task dispatcher testbench: clock, reset, stimulus and verdict.
// Depends on ptd_pkg, the dispatcher RTL and periodic_task_dispatcher_checker.
module periodic_task_dispatcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int TABLE_SIZE          = 16;
    localparam int RANDOM_ITEMS        = 60;
    localparam int CALM_TICKS          = 20;
    localparam int WATCHDOG_LIMIT      = 2000;
    localparam int DRAIN_CYCLES        = 40;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_operation    = '0;
    logic        i_task_present = 1'b0;
    logic [31:0] i_interval     = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic        o_accepted;
    logic [3:0]  o_task_index;
    logic [15:0] o_overruns;
    logic        o_last;

    bit calm         = 1'b0;
    int items_sent   = 0;
    int slots_added  = 0;
    int quiet_cycles = 0;
    int errors;
    int outstanding;
    int dispatches;
    int widest_run;

    periodic_task_dispatcher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_task_present (i_task_present),
        .i_interval     (i_interval),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_accepted     (o_accepted),
        .o_task_index   (o_task_index),
        .o_overruns     (o_overruns),
        .o_last         (o_last)
    );

    periodic_task_dispatcher_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_task_present (i_task_present),
        .i_interval     (i_interval),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind         (o_kind),
        .i_accepted     (o_accepted),
        .i_task_index   (o_task_index),
        .i_overruns     (o_overruns),
        .i_last         (o_last),
        .o_errors       (errors),
        .o_outstanding  (outstanding),
        .o_dispatches   (dispatches),
        .o_widest_run   (widest_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("periodic_task_dispatcher test failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic present,
                             input logic [31:0] ivl);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_task_present <= present;
        i_interval     <= ivl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op != OP_UNUSED) begin
            items_sent++;
        end
        if (op == ptd_pkg::OP_ADD && present && slots_added < TABLE_SIZE) begin
            slots_added++;
        end
    endtask

    task automatic send_tick_burst(input int ticks);
        repeat (ticks) send_item(ptd_pkg::OP_TICK, 1'($urandom), $urandom);
        send_item(ptd_pkg::OP_RUN, 1'($urandom), $urandom);
    endtask

    initial begin
        int pick;
        int stop_at;
        logic with_task;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: rejected add, idle run, tick with nothing to count; then adds, ticks and runs
        send_item(ptd_pkg::OP_ADD, 1'b0, 32'hFFFF_FFFF);
        send_item(ptd_pkg::OP_RUN, 1'b0, 32'h0);
        send_item(ptd_pkg::OP_TICK, 1'b0, 32'h0);
        send_item(ptd_pkg::OP_ADD, 1'b1, 32'h0);
        send_item(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        send_item(ptd_pkg::OP_RUN, 1'b1, 32'hFFFF_FFFF);
        send_item(ptd_pkg::OP_TICK, 1'b1, 32'hFFFF_FFFF);
        send_item(ptd_pkg::OP_RUN, 1'b0, 32'h0);
        send_item(ptd_pkg::OP_ADD, 1'b1, 32'd1);
        send_item(ptd_pkg::OP_ADD, 1'b1, 32'd3);
        send_item(ptd_pkg::OP_ADD, 1'b1, 32'd2);
        send_tick_burst(4);
        send_item(ptd_pkg::OP_RUN, 1'b0, 32'h0);

        // build up overrun counts, no idling on either side
        calm = 1'b1;
        repeat (CALM_TICKS) send_item(ptd_pkg::OP_TICK, 1'($urandom), $urandom);
        send_item(ptd_pkg::OP_RUN, 1'b0, 32'h0);
        send_tick_burst(1);
        calm = 1'b0;

        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < ((slots_added < TABLE_SIZE) ? 5 : 2)) begin
                with_task = ($urandom_range(0, 99) < 85);
                send_item(ptd_pkg::OP_ADD, with_task,
                          with_task ? 32'($urandom_range(0, 6)) : $urandom);
            end else if (pick == 5) begin
                send_item(($urandom_range(0, 1) != 0) ? OP_UNUSED : ptd_pkg::OP_RUN,
                          1'($urandom), $urandom);
            end else begin
                send_tick_burst($urandom_range(1, 8));
            end
        end

        // fill the table, overflow it, then make every slot due for one long run
        while (slots_added < TABLE_SIZE) begin
            send_item(ptd_pkg::OP_ADD, 1'b1, 32'($urandom_range(0, 6)));
        end
        send_item(ptd_pkg::OP_ADD, 1'b1, 32'hFFFF_FFFF);
        send_tick_burst(8);
        send_item(ptd_pkg::OP_RUN, 1'b1, 32'h0);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats into a table of %0d slots, including %0d back-to-back ticks.",
                 items_sent, slots_added, CALM_TICKS);
        $display("Checked %0d dispatches; the longest run emitted %0d of them.",
                 dispatches, widest_run);
        if (errors == 0 && outstanding == 0) begin
            $display("periodic_task_dispatcher test passed");
        end else begin
            $display("periodic_task_dispatcher test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ptd_pkg.sv
sv/ptd_cell.sv
sv/periodic_task_dispatcher.sv
tb/periodic_task_dispatcher_checker.sv
tb/periodic_task_dispatcher_test.sv
